/* hdl/skct_pkg.sv */
// ----------------------------------------------------------------------------
// skct_pkg
// Shared codes, widths and types of the sequence-keyed table: operation and
// status codes, the token that walks the cell chain and the result word.
// ----------------------------------------------------------------------------
package skct_pkg;

  localparam int MaxIdxW = 8;
  localparam int MaxCntW = 9;
  localparam int CapacityDefault = 16;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_CLEAN  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic               vld;
    logic [2:0]         op;
    logic [31:0]        key;
    logic [31:0]        pid;
    logic [31:0]        mask;
    logic               any_match;
    logic               claimed;
    logic               hit;
    logic               replaced;
    logic [MaxIdxW-1:0] slot;
    logic [31:0]        found;
    logic [MaxCntW-1:0] dropped;
  } skct_tok_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic [31:0] found;
    logic [4:0]  count;
    logic [4:0]  removed;
    logic [1:0]  status;
  } skct_res_t;

endpackage

/* hdl/skct_cell.sv */
// ----------------------------------------------------------------------------
// skct_cell
// One table slot: valid bit, sequence number and parent id. Captures its key
// match when an operation is accepted, then acts on the token as it passes
// and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module skct_cell
  import skct_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic [31:0] key_i,
  input  skct_tok_t tok_i,
  output skct_tok_t tok_o,
  output logic      match_o
);

  logic        valid_q, valid_d;
  logic        match_q, match_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] parent_q, parent_d;
  skct_tok_t   tok_q, tok_d;

  always_comb begin
    valid_d  = valid_q;
    seq_d    = seq_q;
    parent_d = parent_q;
    tok_d    = tok_i;
    match_d  = match_q;
    if (start_i) begin
      match_d = valid_q && (seq_q == key_i);
    end
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_INSERT: begin
          if (tok_i.any_match) begin
            if (match_q) begin
              parent_d       = tok_i.pid;
              tok_d.replaced = 1'b1;
              tok_d.slot     = MaxIdxW'(IDX);
            end
          end else if (!valid_q && !tok_i.claimed) begin
            valid_d       = 1'b1;
            seq_d         = tok_i.key;
            parent_d      = tok_i.pid;
            tok_d.claimed = 1'b1;
            tok_d.slot    = MaxIdxW'(IDX);
          end
        end
        OP_LOOKUP: begin
          if (match_q && (((parent_q ^ tok_i.pid) & tok_i.mask) == 32'd0)) begin
            tok_d.hit   = 1'b1;
            tok_d.slot  = MaxIdxW'(IDX);
            tok_d.found = parent_q;
          end
        end
        OP_REMOVE: begin
          if (match_q) begin
            valid_d       = 1'b0;
            tok_d.hit     = 1'b1;
            tok_d.slot    = MaxIdxW'(IDX);
            tok_d.dropped = tok_i.dropped + MaxCntW'(1);
          end
        end
        OP_CLEAN: begin
          if (valid_q && (seq_q < tok_i.key)) begin
            valid_d       = 1'b0;
            tok_d.dropped = tok_i.dropped + MaxCntW'(1);
          end
        end
        OP_CLEAR: begin
          if (valid_q) begin
            valid_d       = 1'b0;
            tok_d.dropped = tok_i.dropped + MaxCntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q    <= seq_d;
    parent_q <= parent_d;
  end

  assign tok_o   = tok_q;
  assign match_o = match_q;

endmodule

/* hdl/seq_keyed_continuation_table_core.sv */
// ----------------------------------------------------------------------------
// seq_keyed_continuation_table_core
// Table of sequence-keyed entries with masked parent-id lookup, built as a
// chain of slot cells that an operation token walks one cell per cycle.
//
// The slave stream takes one operation word: tuser holds the operation code,
// tdata the sequence key, parent id and id mask. The master stream returns
// one result word for each operation: tdata holds hit, slot, found parent id,
// entry count and removed count, tuser the status code.
// On acceptance every cell latches whether it holds the key. The next cycle
// a token enters cell 0 and moves one cell per cycle; when it leaves the last
// cell its result is written to the output register. One operation is in
// the table at a time: no new word is taken until its token leaves the chain.
// Reset empties the table and the output stage. A result that the receiver
// does not take waits in the output register; a second one waits in a
// holding register, and the slave stream is held off while that is full.
// ----------------------------------------------------------------------------
module seq_keyed_continuation_table_core
  import skct_pkg::*;
#(
  parameter int CAPACITY = CapacityDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_seq [31:0], parent_id [63:32], id_mask [95:64]
  input  logic [95:0]  s_axis_tdata,
  // operation [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit [0], slot [4:1], found_parent_id [36:5], entry_count [41:37],
  // removed_count [46:42], zero [47]
  output logic [47:0]  m_axis_tdata,
  // status [1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic                accept;
  logic                done;
  logic                drain;
  logic                busy_q;
  logic                inj_q;
  logic [2:0]          op_q;
  logic [31:0]         key_q, pid_q, mask_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW+4:0]     count_ext;
  logic [MaxCntW-1:0]  removed_sum;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY:0]   tok_vld;
  skct_tok_t           tok_head;
  skct_tok_t           tok [CAPACITY+1];
  skct_tok_t           tail;
  skct_res_t           res;
  skct_res_t           out_q;
  skct_res_t           pend_q;
  logic                out_vld_q;
  logic                pend_vld_q;

  assign s_axis_tready = !busy_q && !pend_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    tok_head           = '0;
    tok_head.vld       = inj_q;
    tok_head.op        = op_q;
    tok_head.key       = key_q;
    tok_head.pid       = pid_q;
    tok_head.mask      = mask_q;
    tok_head.any_match = |match_vec;
  end

  assign tok[0] = tok_head;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    skct_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (accept),
      .key_i   (s_axis_tdata[31:0]),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .match_o (match_vec[g])
    );
  end

  for (genvar v = 0; v <= CAPACITY; v++) begin : g_vld
    assign tok_vld[v] = tok[v].vld;
  end

  assign tail  = tok[CAPACITY];
  assign done  = tail.vld;
  assign drain = out_vld_q && m_axis_tready;

  always_comb begin
    count_d     = count_q + CntW'(tail.claimed) - tail.dropped[CntW-1:0];
    count_ext   = {5'd0, count_d};
    removed_sum = tail.dropped + MaxCntW'(tail.replaced);
    res.hit     = tail.hit;
    res.slot    = tail.slot[3:0];
    res.found   = tail.found;
    res.count   = count_ext[4:0];
    res.removed = removed_sum[4:0];
    case (tail.op)
      OP_INSERT: res.status = (!tail.any_match && !tail.claimed) ? ST_FULL : ST_OK;
      OP_LOOKUP: res.status = tail.hit ? ST_OK : ST_NOTFOUND;
      OP_REMOVE: res.status = tail.hit ? ST_OK : ST_NOTFOUND;
      default:   res.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      inj_q      <= 1'b0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      inj_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        count_q <= count_d;
        if (!out_vld_q || drain) begin
          out_vld_q <= 1'b1;
        end else begin
          pend_vld_q <= 1'b1;
        end
      end else if (drain) begin
        out_vld_q  <= pend_vld_q;
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      key_q  <= s_axis_tdata[31:0];
      pid_q  <= s_axis_tdata[63:32];
      mask_q <= s_axis_tdata[95:64];
    end
    if (done) begin
      if (!out_vld_q || drain) begin
        out_q <= res;
      end else begin
        pend_q <= res;
      end
    end else if (drain && pend_vld_q) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.removed, out_q.count, out_q.found,
                          out_q.slot, out_q.hit};
  assign m_axis_tuser  = out_q.status;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one token in the cell chain");

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("sequence key held by more than one slot");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_pend_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> out_vld_q)
    else $error("held result without a result in the output register");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && inj_q)
    else $error("accepted word did not start a chain pass");

endmodule

/* tb/tb_seq_keyed_continuation_table_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seq_keyed_continuation_table_core
// Drives table operations into the slave stream with random gaps and takes
// the result words with random back-pressure. A local model of the table
// predicts each result; directed rows carry typed results where obvious.
// ----------------------------------------------------------------------------
module tb_seq_keyed_continuation_table_core;
  import skct_pkg::*;

  localparam int Capacity = CapacityDefault;
  localparam int NumDirected = 22;
  localparam int NumRandom = 800;
  localparam int PoolSize = 24;
  localparam int StallLimit = 2000;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] pid;
    logic [31:0] mask;
    logic        typed;
    skct_res_t   res;
  } table_cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  // table image kept by the testbench
  logic         tbl_valid [Capacity];
  logic [31:0]  tbl_seq [Capacity];
  logic [31:0]  tbl_parent [Capacity];
  int           tbl_total;

  skct_res_t    pending_results [$];
  int           mismatches = 0;
  int           stall_cycles = 0;
  bit           steady = 1'b0;

  table_cmd_t directed_cmds [NumDirected] = '{
    '{OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd0, 5'd0, ST_NOTFOUND}},
    '{OP_REMOVE, 32'hffffffff, 32'h0, 32'h0, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd0, 5'd0, ST_NOTFOUND}},
    '{OP_CLEAR, 32'h0, 32'h0, 32'h0, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd0, 5'd0, ST_OK}},
    '{OP_INSERT, 32'h0, 32'hffffffff, 32'h0, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd1, 5'd0, ST_OK}},
    '{OP_INSERT, 32'hffffffff, 32'h0, 32'hffffffff, 1'b1,
      '{1'b0, 4'd1, 32'h0, 5'd2, 5'd0, ST_OK}},
    '{OP_INSERT, 32'h0, 32'h5a5aa5a5, 32'h0, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd2, 5'd1, ST_OK}},
    '{OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1,
      '{1'b1, 4'd0, 32'h5a5aa5a5, 5'd2, 5'd0, ST_OK}},
    '{OP_LOOKUP, 32'h0, 32'hffffffff, 32'hffffffff, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd2, 5'd0, ST_NOTFOUND}},
    '{OP_LOOKUP, 32'hffffffff, 32'h0, 32'hffffffff, 1'b1,
      '{1'b1, 4'd1, 32'h0, 5'd2, 5'd0, ST_OK}},
    '{OP_LOOKUP, 32'h1, 32'h5a5aa5a5, 32'h0, 1'b0, '0},
    '{OP_RSVD_LO, 32'h0, 32'h0, 32'h0, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd2, 5'd0, ST_OK}},
    '{OP_RSVD_HI, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1,
      '{1'b0, 4'd0, 32'h0, 5'd2, 5'd0, ST_OK}},
    '{OP_INSERT, 32'h80000000, 32'h12345678, 32'h0, 1'b0, '0},
    '{OP_INSERT, 32'h7fffffff, 32'h87654321, 32'h0, 1'b0, '0},
    '{OP_CLEAN, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_CLEAN, 32'h80000000, 32'h0, 32'h0, 1'b0, '0},
    '{OP_REMOVE, 32'hffffffff, 32'h0, 32'h0, 1'b0, '0},
    '{OP_REMOVE, 32'hffffffff, 32'h0, 32'h0, 1'b0, '0},
    '{OP_INSERT, 32'h3, 32'hc3c3c3c3, 32'h0, 1'b0, '0},
    '{OP_LOOKUP, 32'h80000000, 32'h12345670, 32'hfffffff0, 1'b0, '0},
    '{OP_CLEAR, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_RSVD_MID, 32'h3, 32'h0, 32'h0, 1'b0, '0}
  };

  seq_keyed_continuation_table_core #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic skct_res_t apply_table_op(input logic [2:0] op, input logic [31:0] key,
                                               input logic [31:0] pid,
                                               input logic [31:0] mask);
    skct_res_t r;
    int s;
    int free_slot;
    r = '0;
    s = -1;
    free_slot = -1;
    for (int i = 0; i < Capacity; i++) begin
      if (tbl_valid[i] && tbl_seq[i] == key && s < 0) s = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    case (op)
      OP_INSERT: begin
        if (s >= 0) begin
          r.removed = 5'd1;
        end else if (free_slot >= 0) begin
          s = free_slot;
          tbl_valid[s] = 1'b1;
          tbl_total++;
        end
        if (s >= 0) begin
          tbl_seq[s] = key;
          tbl_parent[s] = pid;
          r.slot = 4'(s);
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (s >= 0 && (tbl_parent[s] & mask) == (pid & mask)) begin
          r.hit = 1'b1;
          r.slot = 4'(s);
          r.found = tbl_parent[s];
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_REMOVE: begin
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          tbl_total--;
          r.hit = 1'b1;
          r.slot = 4'(s);
          r.removed = 5'd1;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_CLEAN, OP_CLEAR: begin
        for (int i = 0; i < Capacity; i++) begin
          if (tbl_valid[i] && (op == OP_CLEAR || tbl_seq[i] < key)) begin
            tbl_valid[i] = 1'b0;
            tbl_total--;
            r.removed = r.removed + 5'd1;
          end
        end
      end
      default: ;
    endcase
    r.count = 5'(tbl_total);
    return r;
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [31:0] key, input logic [31:0] pid,
                           input logic [31:0] mask, input logic typed,
                           input skct_res_t typed_res);
    skct_res_t want;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {mask, pid, key};
    do @(posedge clk_i); while (!s_axis_tready);
    want = apply_table_op(op, key, pid, mask);
    if (typed) want = typed_res;
    pending_results.push_back(want);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t: %s got %h want %h", $time, field, got, want);
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    skct_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.hit) note_mismatch("hit", m_axis_tdata[0], want.hit);
        if (m_axis_tdata[4:1] !== want.slot) note_mismatch("slot", m_axis_tdata[4:1], want.slot);
        if (m_axis_tdata[36:5] !== want.found) begin
          note_mismatch("found_parent_id", m_axis_tdata[36:5], want.found);
        end
        if (m_axis_tdata[41:37] !== want.count) begin
          note_mismatch("entry_count", m_axis_tdata[41:37], want.count);
        end
        if (m_axis_tdata[46:42] !== want.removed) begin
          note_mismatch("removed_count", m_axis_tdata[46:42], want.removed);
        end
        if (m_axis_tdata[47] !== 1'b0) note_mismatch("pad bit", m_axis_tdata[47], 1'b0);
        if (m_axis_tuser !== want.status) note_mismatch("status", m_axis_tuser, want.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("seq_keyed_continuation_table_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] key_pool [PoolSize];
    logic [31:0] k;
    logic [31:0] p;
    logic [31:0] m;
    logic [31:0] kept;
    logic [2:0]  op;
    bit          known;
    int          r;
    int          phase;
    int          done;
    for (int i = 0; i < Capacity; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_seq[i] = '0;
      tbl_parent[i] = '0;
    end
    tbl_total = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_cmds[i]) begin
      send_word(directed_cmds[i].op, directed_cmds[i].key, directed_cmds[i].pid,
                directed_cmds[i].mask, directed_cmds[i].typed, directed_cmds[i].res);
    end

    done = 0;
    while (done < NumRandom) begin
      if (done % 100 == 0) begin
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[PoolSize-1] = 32'hffffffff;
      end
      steady = (done >= 350 && done < 500);
      phase = (done / 50) % 3;
      r = $urandom_range(99);
      // fill-heavy, balanced and drain-heavy phases
      case (phase)
        0: op = r < 65 ? OP_INSERT : r < 85 ? OP_LOOKUP : r < 93 ? OP_REMOVE :
                r < 97 ? OP_CLEAN : 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        1: op = r < 35 ? OP_INSERT : r < 70 ? OP_LOOKUP : r < 85 ? OP_REMOVE :
                r < 93 ? OP_CLEAN : r < 97 ? OP_CLEAR :
                3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        default: op = r < 20 ? OP_INSERT : r < 50 ? OP_LOOKUP : r < 80 ? OP_REMOVE :
                      r < 90 ? OP_CLEAN : r < 97 ? OP_CLEAR :
                      3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      endcase
      if ($urandom_range(9) == 0 || (op == OP_CLEAN && $urandom_range(1) == 0)) begin
        k = $urandom();
      end else begin
        k = key_pool[$urandom_range(PoolSize-1)];
      end
      p = $urandom();
      case ($urandom_range(3))
        0: m = '0;
        1: m = '1;
        default: m = $urandom();
      endcase
      if (op == OP_LOOKUP) begin
        known = 1'b0;
        kept = '0;
        for (int i = 0; i < Capacity; i++) begin
          if (tbl_valid[i] && tbl_seq[i] == k) begin
            known = 1'b1;
            kept = tbl_parent[i];
          end
        end
        // mostly a matching id with noise outside the mask
        if (known && $urandom_range(3) != 0) p = kept ^ (p & ~m);
      end
      send_word(op, k, p, m, 1'b0, '0);
      if (op <= OP_CLEAR) done++;
    end
    steady = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3 * Capacity) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("seq_keyed_continuation_table_core: match");
    end else begin
      $display("seq_keyed_continuation_table_core: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/skct_pkg.sv
hdl/skct_cell.sv
hdl/seq_keyed_continuation_table_core.sv
tb/tb_seq_keyed_continuation_table_core.sv
